@@ src/ipwm_pkg.sv @@
// package for the ip wildcard pattern matcher
// holds beat structs, pattern kinds, parse modes, sequencer states and char helpers
package ipwm_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam logic [7:0] OCTET_MAX = 8'd255;
  localparam logic [8:0] ACCUM_SAT = 9'd256;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [3:0] DEC_TEN  = 4'd10;

  typedef enum logic [1:0] {
    KIND_EXACT = 2'd0,
    KIND_ANY   = 2'd1,
    KIND_LIST  = 2'd2,
    KIND_RANGE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_ALL   = 2'd1,
    MODE_LIST  = 2'd2,
    MODE_RANGE = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    OP_RULE = 1'b0,
    OP_ADDR = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_SEARCH,
    ST_FINAL,
    ST_CLOSE,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic report_kind;
    logic well_formed;
    logic matched;
  } out_beat_t;

  // search request and result between sequencer and list search unit
  typedef struct packed {
    logic       start;
    logic [1:0] slot;
    logic [7:0] value;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_rsp_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

@@ src/ipwm_list_search.sv @@
// list search unit: walks one octet's stored list, one entry per cycle
// holds the list memory; depends on ipwm_pkg
module ipwm_list_search #(
  parameter int unsigned LIST_DEPTH = ipwm_pkg::LIST_DEPTH_DEF,
  parameter int unsigned IDX_W = $clog2(LIST_DEPTH + 1),
  parameter int unsigned ADR_W = $clog2(4 * LIST_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [ADR_W-1:0]    wr_addr,
  input  logic [7:0]          wr_data,
  input  logic [IDX_W-1:0]    count,
  input  ipwm_pkg::srch_req_t req,
  output ipwm_pkg::srch_rsp_t rsp
);

  logic [7:0] mem [4*LIST_DEPTH];
  logic [7:0] rd_data_r;
  logic       busy_r, busy_nxt;
  logic       rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [7:0] val_r, val_nxt;
  logic [ADR_W-1:0] rd_addr;
  logic       rd_en;
  logic       hit;

  // memory write and registered read
  assign rd_addr = ADR_W'(slot_r * LIST_DEPTH) + ADR_W'(idx_r);
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign hit = rd_vld_r && (rd_data_r == val_r);

  // walk control
  always_comb begin
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    val_nxt    = val_r;
    rd_vld_nxt = 1'b0;
    rd_en      = 1'b0;
    rsp.done   = 1'b0;
    rsp.hit    = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      slot_nxt = req.slot;
      val_nxt  = req.value;
    end else if (busy_r) begin
      if (hit || (idx_r >= count && !rd_vld_r) ||
          (idx_r >= count && rd_vld_r)) begin
        rsp.done = 1'b1;
        rsp.hit  = hit;
        busy_nxt = 1'b0;
      end else begin
        rd_en      = 1'b1;
        rd_vld_nxt = 1'b1;
        idx_nxt    = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
    idx_r  <= idx_nxt;
    slot_r <= slot_nxt;
    val_r  <= val_nxt;
  end

endmodule

@@ src/ip_wildcard_pattern_matcher.sv @@
// ip wildcard pattern matcher: each character beat is accepted in idle and
// parsed in parse; a final character then goes on through close (and final or
// search where needed) before its report, and no new beat is taken until the
// report is taken. an address octet closing on a list pattern waits in search.
// synchronous active-low reset clears all control, pattern and match state;
// list memory is not cleared and is only read below the stored list count.
module ip_wildcard_pattern_matcher #(
  parameter int unsigned LIST_DEPTH = ipwm_pkg::LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipwm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ipwm_pkg::out_beat_t out_data
);

  localparam int unsigned IDX_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ADR_W = $clog2(4 * LIST_DEPTH);

  ipwm_pkg::state_t state_r, state_nxt;
  ipwm_pkg::in_beat_t beat_r;

  logic [2:0] slot_r;
  logic [8:0] acc_r;
  logic seen_r, started_r, trail_r, err_r, star_r, rvalid_r, msf_r;
  ipwm_pkg::mode_t mode_r;
  ipwm_pkg::kind_t kind_r [4];
  logic [7:0] lo_r [4];
  logic [7:0] hi_r [4];
  logic [IDX_W-1:0] cnt_r [4];
  logic well_r;

  // next-value copies of the per-string state
  logic [2:0] slot_n;
  logic [8:0] acc_n;
  logic seen_n, started_n, trail_n, err_n, star_n, rvalid_n, msf_n;
  ipwm_pkg::mode_t mode_n;
  ipwm_pkg::kind_t kind_n [4];
  logic [7:0] lo_n [4];
  logic [7:0] hi_n [4];
  logic [IDX_W-1:0] cnt_n [4];
  logic well_n;

  logic wr_en;
  logic [ADR_W-1:0] wr_addr;
  logic [7:0] wr_data;
  ipwm_pkg::srch_req_t req;
  ipwm_pkg::srch_rsp_t rsp;
  logic [1:0] s;
  logic [7:0] c;
  logic [12:0] prod;
  logic [8:0] dig_acc;

  assign s = slot_r[1:0];
  assign c = beat_r.char_code;

  ipwm_list_search #(
    .LIST_DEPTH(LIST_DEPTH), .IDX_W(IDX_W), .ADR_W(ADR_W)
  ) u_search (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(wr_addr),
    .wr_data(wr_data), .count(cnt_r[s]), .req(req), .rsp(rsp)
  );

  // accumulate one decimal digit, saturating
  assign prod = 13'(acc_r) * 13'(ipwm_pkg::DEC_TEN) + 13'(c - ipwm_pkg::CH_ZERO);
  assign dig_acc = (prod > 13'(ipwm_pkg::OCTET_MAX)) ? ipwm_pkg::ACCUM_SAT : prod[8:0];

  // handshake
  assign in_ready  = (state_r == ipwm_pkg::ST_IDLE);
  assign out_valid = (state_r == ipwm_pkg::ST_REPORT);
  assign out_data.report_kind = beat_r.op;
  assign out_data.well_formed = well_r;
  assign out_data.matched = (beat_r.op == ipwm_pkg::OP_ADDR) && rvalid_r && well_r && msf_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipwm_pkg::ST_IDLE:   if (in_valid) state_nxt = ipwm_pkg::ST_PARSE;
      ipwm_pkg::ST_PARSE:  begin
        if (req.start) state_nxt = ipwm_pkg::ST_SEARCH;
        else if (beat_r.last_char) state_nxt = ipwm_pkg::ST_FINAL;
        else state_nxt = ipwm_pkg::ST_IDLE;
      end
      ipwm_pkg::ST_SEARCH: begin
        if (rsp.done) state_nxt = beat_r.last_char ? ipwm_pkg::ST_CLOSE
                                                  : ipwm_pkg::ST_IDLE;
      end
      ipwm_pkg::ST_FINAL:  state_nxt = req.start ? ipwm_pkg::ST_SEARCH : ipwm_pkg::ST_CLOSE;
      ipwm_pkg::ST_CLOSE:  state_nxt = ipwm_pkg::ST_REPORT;
      ipwm_pkg::ST_REPORT: if (out_ready) state_nxt = ipwm_pkg::ST_IDLE;
      default:             state_nxt = ipwm_pkg::ST_IDLE;
    endcase
  end

  // datapath: character parsing, segment closing, octet compare
  always_comb begin
    logic blank;
    logic do_close;
    slot_n = slot_r; acc_n = acc_r; seen_n = seen_r; started_n = started_r;
    trail_n = trail_r; err_n = err_r; star_n = star_r; rvalid_n = rvalid_r;
    msf_n = msf_r; mode_n = mode_r; well_n = well_r;
    kind_n = kind_r; lo_n = lo_r; hi_n = hi_r; cnt_n = cnt_r;
    wr_en = 1'b0; wr_addr = '0; wr_data = acc_r[7:0];
    req.start = 1'b0; req.slot = s; req.value = acc_r[7:0];
    blank = ipwm_pkg::is_blank(c);
    do_close = 1'b0;
    unique case (state_r)
      ipwm_pkg::ST_PARSE: begin
        if (beat_r.op == ipwm_pkg::OP_RULE) rvalid_n = 1'b0;
        if (!err_r && slot_r < 3'd4) begin
          if (blank || c == ipwm_pkg::CH_NUL) begin
            if (started_r) trail_n = 1'b1;
            else if (c == ipwm_pkg::CH_NUL) err_n = 1'b1;
          end else if (trail_r || (star_r && c != ipwm_pkg::CH_DOT)) begin
            err_n = 1'b1;
          end else begin
            started_n = 1'b1;
            star_n = 1'b0;
            if (ipwm_pkg::is_digit(c)) begin
              acc_n = dig_acc;
              seen_n = 1'b1;
            end else if (c == ipwm_pkg::CH_DOT) begin
              do_close = 1'b1;
            end else if (beat_r.op == ipwm_pkg::OP_ADDR) begin
              err_n = 1'b1;
            end else if (c == ipwm_pkg::CH_STAR) begin
              if (seen_r || mode_r == ipwm_pkg::MODE_RANGE || mode_r == ipwm_pkg::MODE_LIST)
                err_n = 1'b1;
              else begin
                mode_n = ipwm_pkg::MODE_ALL;
                star_n = 1'b1;
              end
            end else if (c == ipwm_pkg::CH_COMMA) begin
              if (!seen_r || mode_r == ipwm_pkg::MODE_RANGE || mode_r == ipwm_pkg::MODE_ALL
                  || acc_r[8]) begin
                err_n = 1'b1;
              end else begin
                logic [IDX_W-1:0] base;
                base = (mode_r != ipwm_pkg::MODE_LIST) ? '0 : cnt_r[s];
                mode_n = ipwm_pkg::MODE_LIST;
                if (32'(base) >= LIST_DEPTH) begin
                  err_n = 1'b1;
                  cnt_n[s] = base;
                end else begin
                  wr_en = 1'b1;
                  wr_addr = ADR_W'(s * LIST_DEPTH) + ADR_W'(base);
                  cnt_n[s] = base + 1'b1;
                end
                seen_n = 1'b0;
                acc_n = '0;
              end
            end else if (c == ipwm_pkg::CH_DASH) begin
              if (!seen_r || mode_r != ipwm_pkg::MODE_NONE || acc_r[8]) err_n = 1'b1;
              else begin
                lo_n[s] = acc_r[7:0];
                mode_n = ipwm_pkg::MODE_RANGE;
                seen_n = 1'b0;
                acc_n = '0;
              end
            end else begin
              err_n = 1'b1;
            end
          end
        end
      end
      ipwm_pkg::ST_FINAL: begin
        if (!err_r && slot_r == 3'd3) do_close = 1'b1;
      end
      ipwm_pkg::ST_SEARCH: begin
        if (rsp.done) begin
          if (!rsp.hit) msf_n = 1'b0;
          seen_n = 1'b0;
          acc_n = '0;
          slot_n = slot_r + 3'd1;
        end
      end
      ipwm_pkg::ST_CLOSE: begin
        well_n = !err_r && slot_r == 3'd4;
        if (beat_r.op == ipwm_pkg::OP_RULE) rvalid_n = !err_r && slot_r == 3'd4;
      end
      ipwm_pkg::ST_REPORT: begin
        if (out_ready) begin
          slot_n = '0; acc_n = '0; seen_n = 1'b0; started_n = 1'b0; trail_n = 1'b0;
          err_n = 1'b0; mode_n = ipwm_pkg::MODE_NONE; star_n = 1'b0; msf_n = 1'b1;
        end
      end
      default: ;
    endcase

    // closing a segment or octet
    if (do_close) begin
      if (beat_r.op == ipwm_pkg::OP_RULE) begin
        if (acc_r[8] || (!seen_r && mode_r != ipwm_pkg::MODE_ALL)) begin
          err_n = 1'b1;
        end else begin
          unique case (mode_r)
            ipwm_pkg::MODE_RANGE: begin
              kind_n[s] = ipwm_pkg::KIND_RANGE;
              if (lo_r[s] > acc_r[7:0]) begin
                lo_n[s] = acc_r[7:0];
                hi_n[s] = lo_r[s];
              end else begin
                hi_n[s] = acc_r[7:0];
              end
            end
            ipwm_pkg::MODE_LIST: begin
              kind_n[s] = ipwm_pkg::KIND_LIST;
              if (32'(cnt_r[s]) >= LIST_DEPTH) err_n = 1'b1;
              else begin
                wr_en = 1'b1;
                wr_addr = ADR_W'(s * LIST_DEPTH) + ADR_W'(cnt_r[s]);
                cnt_n[s] = cnt_r[s] + 1'b1;
              end
            end
            ipwm_pkg::MODE_ALL: kind_n[s] = ipwm_pkg::KIND_ANY;
            default: begin
              kind_n[s] = ipwm_pkg::KIND_EXACT;
              lo_n[s] = acc_r[7:0];
            end
          endcase
          if (!err_n) begin
            mode_n = ipwm_pkg::MODE_NONE;
            seen_n = 1'b0;
            acc_n = '0;
            slot_n = slot_r + 3'd1;
          end
        end
      end else begin
        if (acc_r[8] || !seen_r) begin
          err_n = 1'b1;
        end else if (rvalid_r && kind_r[s] == ipwm_pkg::KIND_LIST) begin
          req.start = 1'b1;
        end else begin
          if (rvalid_r) begin
            unique case (kind_r[s])
              ipwm_pkg::KIND_EXACT: if (acc_r[7:0] != lo_r[s]) msf_n = 1'b0;
              ipwm_pkg::KIND_RANGE:
                if (acc_r[7:0] < lo_r[s] || acc_r[7:0] > hi_r[s]) msf_n = 1'b0;
              default: ;
            endcase
          end
          seen_n = 1'b0;
          acc_n = '0;
          slot_n = slot_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipwm_pkg::ST_IDLE;
      slot_r <= '0; acc_r <= '0; seen_r <= 1'b0; started_r <= 1'b0; trail_r <= 1'b0;
      err_r <= 1'b0; star_r <= 1'b0; rvalid_r <= 1'b0; msf_r <= 1'b1;
      mode_r <= ipwm_pkg::MODE_NONE; well_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        kind_r[i] <= ipwm_pkg::KIND_EXACT; lo_r[i] <= '0; hi_r[i] <= '0; cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_n; acc_r <= acc_n; seen_r <= seen_n; started_r <= started_n;
      trail_r <= trail_n; err_r <= err_n; star_r <= star_n; rvalid_r <= rvalid_n;
      msf_r <= msf_n; mode_r <= mode_n; well_r <= well_n;
      kind_r <= kind_n; lo_r <= lo_n; hi_r <= hi_n; cnt_r <= cnt_n;
    end
    if (in_valid && in_ready) beat_r <= in_data;
  end

  // checks
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n) slot_r <= 3'd4)
    else $error("octet slot past four");
  a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("report changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("accepting while a report waits");
  a_match_needs_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.matched |-> rvalid_r && out_data.well_formed)
    else $error("match without valid rule");

endmodule
